[src/jpeg_exif_ifd_extractor_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Exif IFD0 extractor
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef JPEG_EXIF_IFD_EXTRACTOR_TOP_DEFINES_SVH
`define JPEG_EXIF_IFD_EXTRACTOR_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define JEXIF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition on one edge implies a condition on the next edge
`define JEXIF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/jexif_pkg.sv]
// ----------------------------------------------------------------------------
// jexif_pkg
// Types, codes and helper functions of the Exif IFD0 extractor.
// ----------------------------------------------------------------------------
package jexif_pkg;

    typedef enum logic [3:0] {
        PH_SOI0   = 4'd0,
        PH_SOI1   = 4'd1,
        PH_MARK0  = 4'd2,
        PH_MARK1  = 4'd3,
        PH_SLEN0  = 4'd4,
        PH_SLEN1  = 4'd5,
        PH_SKIP   = 4'd6,
        PH_ALEN0  = 4'd7,
        PH_ALEN1  = 4'd8,
        PH_HDR    = 4'd9,
        PH_ORDER  = 4'd10,
        PH_MAGIC  = 4'd11,
        PH_OFFSET = 4'd12,
        PH_GAP    = 4'd13,
        PH_COUNT  = 4'd14,
        PH_ENTRY  = 4'd15
    } t_phase;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_NOT_JPEG   = 4'd1;
    localparam logic [3:0] ST_NO_EXIF    = 4'd2;
    localparam logic [3:0] ST_BAD_LENGTH = 4'd3;
    localparam logic [3:0] ST_BAD_HEADER = 4'd4;
    localparam logic [3:0] ST_BAD_ORDER  = 4'd5;
    localparam logic [3:0] ST_BAD_MAGIC  = 4'd6;
    localparam logic [3:0] ST_BAD_OFFSET = 4'd7;
    localparam logic [3:0] ST_EARLY_END  = 4'd8;

    localparam logic       KIND_ENTRY  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [7:0] MARK_BYTE   = 8'hFF;
    localparam logic [7:0] SOI_BYTE    = 8'hD8;
    localparam logic [7:0] APP1_BYTE   = 8'hE1;
    localparam logic [7:0] ORDER_II    = 8'h49;
    localparam logic [7:0] ORDER_MM    = 8'h4D;
    localparam logic [31:0] TIFF_MAGIC = 32'd42;
    localparam logic [3:0] ENTRY_LAST  = 4'd11;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [15:0] num;
        logic [15:0] tag;
        logic [15:0] ttype;
        logic [31:0] cnt;
        logic [31:0] val;
        logic [3:0]  status;
        logic        last;
    } t_result;

    // second implies first: results go out as first then second
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    function automatic logic [7:0] exif_sig(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h45;
            4'd1:    v = 8'h78;
            4'd2:    v = 8'h69;
            4'd3:    v = 8'h66;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // add one byte to a field in file byte order
    function automatic logic [31:0] gather(input logic [31:0] w, input logic [7:0] b,
                                           input logic [1:0] pos, input logic le);
        logic [31:0] r;
        if (le) begin
            r = w | ({24'd0, b} << {pos, 3'b000});
        end else begin
            r = {w[23:0], b};
        end
        return r;
    endfunction

endpackage

[src/jexif_parse.sv]
// ----------------------------------------------------------------------------
// jexif_parse
// Per-byte parser state and next-state logic; emits up to two results.
// ----------------------------------------------------------------------------
module jexif_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_eof,
    output jexif_pkg::t_push    o_push,
    output jexif_pkg::t_result  o_res0,
    output jexif_pkg::t_result  o_res1
);

    jexif_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_seg, n_seg;
    logic [15:0] r_tpos, n_tpos;
    logic        r_le, n_le;
    logic [31:0] r_word, n_word;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_left, n_left;
    logic [15:0] r_eidx, n_eidx;
    logic [31:0] r_held_tt, n_held_tt;
    logic [31:0] r_held_cnt, n_held_cnt;
    logic        r_fin;

    logic        fin_now;
    logic [3:0]  fin_code;
    logic        ent_push;
    logic [3:0]  ent_idx;
    logic [1:0]  gpos;
    logic [31:0] g;
    logic [15:0] len;
    logic [15:0] skip_dec;
    logic [19:0] need;
    jexif_pkg::t_result ent_res, st_res;

    assign ent_idx = (r_idx > jexif_pkg::ENTRY_LAST) ? 4'd0 : r_idx;
    always_comb begin
        if (r_phase == jexif_pkg::PH_ENTRY) begin
            gpos = (ent_idx < 4'd4) ? {1'b0, ent_idx[0]} : ent_idx[1:0];
        end else begin
            gpos = r_idx[1:0];
        end
    end
    assign g        = jexif_pkg::gather(r_word, i_byte, gpos, r_le);
    assign len      = {r_word[7:0], i_byte};
    assign skip_dec = (r_skip != 16'd0) ? r_skip - 16'd1 : r_skip;
    assign need     = {1'b0, g[15:0], 3'b000} + {2'b00, g[15:0], 2'b00};

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_seg      = r_seg;
        n_tpos     = r_tpos;
        n_le       = r_le;
        n_word     = r_word;
        n_idx      = r_idx;
        n_left     = r_left;
        n_eidx     = r_eidx;
        n_held_tt  = r_held_tt;
        n_held_cnt = r_held_cnt;
        fin_now    = 1'b0;
        fin_code   = jexif_pkg::ST_OK;
        ent_push   = 1'b0;

        // segment and TIFF byte accounting inside APP1
        if (r_phase >= jexif_pkg::PH_HDR) begin
            if (r_seg != 16'd0) n_seg = r_seg - 16'd1;
            if (r_phase >= jexif_pkg::PH_ORDER && r_tpos != 16'hFFFF) begin
                n_tpos = r_tpos + 16'd1;
            end
        end

        case (r_phase)
            jexif_pkg::PH_SOI0: begin
                if (i_byte != jexif_pkg::MARK_BYTE) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_NOT_JPEG;
                end else n_phase = jexif_pkg::PH_SOI1;
            end
            jexif_pkg::PH_SOI1: begin
                if (i_byte != jexif_pkg::SOI_BYTE) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_NOT_JPEG;
                end else n_phase = jexif_pkg::PH_MARK0;
            end
            jexif_pkg::PH_MARK0: begin
                if (i_byte != jexif_pkg::MARK_BYTE) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_NO_EXIF;
                end else n_phase = jexif_pkg::PH_MARK1;
            end
            jexif_pkg::PH_MARK1: begin
                n_phase = (i_byte == jexif_pkg::APP1_BYTE) ? jexif_pkg::PH_ALEN0
                                                           : jexif_pkg::PH_SLEN0;
            end
            jexif_pkg::PH_SLEN0: begin
                n_word  = {24'd0, i_byte};
                n_phase = jexif_pkg::PH_SLEN1;
            end
            jexif_pkg::PH_ALEN0: begin
                n_word  = {24'd0, i_byte};
                n_phase = jexif_pkg::PH_ALEN1;
            end
            jexif_pkg::PH_SLEN1: begin
                n_word = 32'd0;
                if (len < 16'd2) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_LENGTH;
                end else begin
                    n_skip  = len - 16'd2;
                    n_phase = (len != 16'd2) ? jexif_pkg::PH_SKIP : jexif_pkg::PH_MARK0;
                end
            end
            jexif_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) n_phase = jexif_pkg::PH_MARK0;
            end
            jexif_pkg::PH_ALEN1: begin
                n_word = 32'd0;
                if (len < 16'd2) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_LENGTH;
                end else if (len < 16'd16) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_HEADER;
                end else begin
                    n_seg   = len - 16'd2;
                    n_tpos  = 16'd0;
                    n_idx   = 4'd0;
                    n_phase = jexif_pkg::PH_HDR;
                end
            end
            jexif_pkg::PH_HDR: begin
                if (i_byte != jexif_pkg::exif_sig(r_idx)) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_HEADER;
                end else if (r_idx >= 4'd5) begin
                    n_idx   = 4'd0;
                    n_phase = jexif_pkg::PH_ORDER;
                end else n_idx = r_idx + 4'd1;
            end
            jexif_pkg::PH_ORDER: begin
                if (r_idx == 4'd0) begin
                    n_word = {24'd0, i_byte};
                    n_idx  = 4'd1;
                end else if (r_word == {24'd0, jexif_pkg::ORDER_II} &&
                             i_byte == jexif_pkg::ORDER_II) begin
                    n_le = 1'b1; n_word = 32'd0; n_idx = 4'd0;
                    n_phase = jexif_pkg::PH_MAGIC;
                end else if (r_word == {24'd0, jexif_pkg::ORDER_MM} &&
                             i_byte == jexif_pkg::ORDER_MM) begin
                    n_le = 1'b0; n_word = 32'd0; n_idx = 4'd0;
                    n_phase = jexif_pkg::PH_MAGIC;
                end else begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_ORDER;
                end
            end
            jexif_pkg::PH_MAGIC: begin
                n_word = g;
                if (r_idx == 4'd0) n_idx = 4'd1;
                else if (g != jexif_pkg::TIFF_MAGIC) begin
                    fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_MAGIC;
                end else begin
                    n_word = 32'd0; n_idx = 4'd0;
                    n_phase = jexif_pkg::PH_OFFSET;
                end
            end
            jexif_pkg::PH_OFFSET: begin
                n_word = g;
                if (r_idx < 4'd3) n_idx = r_idx + 4'd1;
                else begin
                    n_idx = 4'd0;
                    // offset - 8 + 2 count bytes must fit in the segment
                    if (g < 32'd8 || (g - 32'd6) > {16'd0, n_seg}) begin
                        fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_OFFSET;
                    end else begin
                        n_skip  = g[15:0] - n_tpos;
                        n_word  = 32'd0;
                        n_phase = (g[15:0] != n_tpos) ? jexif_pkg::PH_GAP
                                                      : jexif_pkg::PH_COUNT;
                    end
                end
            end
            jexif_pkg::PH_GAP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) n_phase = jexif_pkg::PH_COUNT;
            end
            jexif_pkg::PH_COUNT: begin
                n_word = g;
                if (r_idx == 4'd0) n_idx = 4'd1;
                else begin
                    n_idx  = 4'd0;
                    n_left = g[15:0];
                    n_word = 32'd0;
                    n_eidx = 16'd0;
                    if (need > {4'd0, n_seg}) begin
                        fin_now = 1'b1; fin_code = jexif_pkg::ST_BAD_OFFSET;
                    end else if (g[15:0] == 16'd0) begin
                        fin_now = 1'b1; fin_code = jexif_pkg::ST_OK;
                    end else n_phase = jexif_pkg::PH_ENTRY;
                end
            end
            jexif_pkg::PH_ENTRY: begin
                n_word = g;
                if (ent_idx == 4'd1) begin
                    n_held_tt = {g[15:0], 16'd0}; n_word = 32'd0;
                end else if (ent_idx == 4'd3) begin
                    n_held_tt = r_held_tt | {16'd0, g[15:0]}; n_word = 32'd0;
                end else if (ent_idx == 4'd7) begin
                    n_held_cnt = g; n_word = 32'd0;
                end
                if (ent_idx < jexif_pkg::ENTRY_LAST) n_idx = ent_idx + 4'd1;
                else begin
                    ent_push = 1'b1;
                    n_word   = 32'd0;
                    n_idx    = 4'd0;
                    n_eidx   = r_eidx + 16'd1;
                    n_left   = (r_left != 16'd0) ? r_left - 16'd1 : r_left;
                    if (n_left == 16'd0) begin
                        fin_now = 1'b1; fin_code = jexif_pkg::ST_OK;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        ent_res.kind   = jexif_pkg::KIND_ENTRY;
        ent_res.num    = r_eidx;
        ent_res.tag    = r_held_tt[31:16];
        ent_res.ttype  = r_held_tt[15:0];
        ent_res.cnt    = r_held_cnt;
        ent_res.val    = g;
        ent_res.status = jexif_pkg::ST_OK;
        ent_res.last   = 1'b0;

        st_res.kind    = jexif_pkg::KIND_STATUS;
        st_res.num     = n_eidx;
        st_res.tag     = 16'd0;
        st_res.ttype   = 16'd0;
        st_res.cnt     = 32'd0;
        st_res.val     = 32'd0;
        st_res.status  = fin_now ? fin_code : jexif_pkg::ST_EARLY_END;
        st_res.last    = 1'b1;

        o_res0        = ent_push ? ent_res : st_res;
        o_res1        = st_res;
        o_push.first  = i_valid && !r_fin && (ent_push || fin_now || i_eof);
        o_push.second = i_valid && !r_fin && ent_push && (fin_now || i_eof);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_eof)) begin
            // end of file returns the parser to its start state
            r_phase    <= jexif_pkg::PH_SOI0;
            r_skip     <= 16'd0;
            r_seg      <= 16'd0;
            r_tpos     <= 16'd0;
            r_le       <= 1'b0;
            r_word     <= 32'd0;
            r_idx      <= 4'd0;
            r_left     <= 16'd0;
            r_eidx     <= 16'd0;
            r_held_tt  <= 32'd0;
            r_held_cnt <= 32'd0;
            r_fin      <= 1'b0;
        end else if (i_valid && !r_fin) begin
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_seg      <= n_seg;
            r_tpos     <= n_tpos;
            r_le       <= n_le;
            r_word     <= n_word;
            r_idx      <= n_idx;
            r_left     <= n_left;
            r_eidx     <= n_eidx;
            r_held_tt  <= n_held_tt;
            r_held_cnt <= n_held_cnt;
            r_fin      <= fin_now;
        end
    end

endmodule

[src/jexif_outq.sv]
// ----------------------------------------------------------------------------
// jexif_outq
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`include "jpeg_exif_ifd_extractor_top_defines.svh"

module jexif_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jexif_pkg::t_push    i_push,
    input  jexif_pkg::t_result  i_res0,
    input  jexif_pkg::t_result  i_res1,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output jexif_pkg::t_result  o_res
);

    jexif_pkg::t_result r_mem [jexif_pkg::Q_DEPTH];
    logic [jexif_pkg::Q_AW-1:0] r_wr, n_wr;
    logic [jexif_pkg::Q_AW-1:0] r_rd, n_rd;
    logic [jexif_pkg::Q_CW-1:0] r_count, n_count;
    logic                       pop;
    logic [jexif_pkg::Q_AW-1:0] wr_next;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room  = (r_count <= jexif_pkg::Q_CW'(jexif_pkg::Q_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + 1'b1;

    always_comb begin
        n_wr    = r_wr + jexif_pkg::Q_AW'(i_push.first) + jexif_pkg::Q_AW'(i_push.second);
        n_rd    = r_rd + jexif_pkg::Q_AW'(pop);
        n_count = r_count + jexif_pkg::Q_CW'(i_push.first)
                + jexif_pkg::Q_CW'(i_push.second) - jexif_pkg::Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) r_mem[r_wr] <= i_res0;
        if (i_push.second) r_mem[wr_next] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `JEXIF_ASSERT_ALWAYS(a_count_bound, r_count <= jexif_pkg::Q_CW'(jexif_pkg::Q_DEPTH), "result queue count overflow")
    `JEXIF_ASSERT_ALWAYS(a_push_room, !i_push.first || o_room, "results pushed without two free slots")
    `JEXIF_ASSERT_ALWAYS(a_push_order, !i_push.second || i_push.first, "second result pushed alone")
    `JEXIF_ASSERT_NEXT(a_pop_only, pop && !i_push.first, r_count == $past(r_count) - 1'b1, "queue count did not drop on a pop")

endmodule

[src/jpeg_exif_ifd_extractor_top.sv]
// ----------------------------------------------------------------------------
// jpeg_exif_ifd_extractor_top
// Reads a JPEG file byte by byte and lists the entries of the Exif IFD0.
// ----------------------------------------------------------------------------
// Takes one file byte per clock. Each byte is registered, parsed
// combinationally and its results are written into a four-slot result
// queue, from which they are read out. The byte that completes the
// last directory entry gives two results (the entry, then the final status);
// the input register holds its byte while the queue has fewer than two free
// slots, so sustained input rate is one byte per clock as long as results are
// taken at the rate they are made. Bytes after the final status are dropped
// until tlast, after which the next byte starts a new file.

module jpeg_exif_ifd_extractor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] file_byte
    input  logic           s_axis_tlast,   // end_of_file
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // [15:0] entry_number, [31:16] tag_id, [47:32] tag_type,
    // [79:48] value_count, [111:80] value_or_offset, [115:112] status, rest 0
    output logic [119:0]   m_axis_tdata,
    output logic           m_axis_tuser,   // result_kind
    output logic           m_axis_tlast    // last_of_run
);

    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_eof;
    logic                room;
    logic                proc;
    jexif_pkg::t_push    push;
    jexif_pkg::t_result  res0, res1, qres;

    assign proc          = r_in_vld && room;
    // take no request while in reset
    assign s_axis_tready = i_rst_n && (!r_in_vld || proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eof  <= s_axis_tlast;
        end
    end

    jexif_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (proc),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    jexif_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (qres)
    );

    assign m_axis_tdata = {4'd0, qres.status, qres.val, qres.cnt,
                           qres.ttype, qres.tag, qres.num};
    assign m_axis_tuser = qres.kind;
    assign m_axis_tlast = qres.last;

endmodule

[test/jpeg_exif_ifd_extractor_top_test.sv]
// ----------------------------------------------------------------------------
// jpeg_exif_ifd_extractor_top_test
// Self-checking bench for the Exif IFD0 extractor.
// ----------------------------------------------------------------------------
// Builds JPEG files byte by byte: well-formed Exif files in both byte orders,
// files with one flaw planted in a chosen field, truncated files and noise.
// Each accepted byte runs through a parser model kept in the bench; the
// directory entries and final status it yields are queued and compared field
// by field with every result the block hands out. Both stream sides idle in
// random bursts until the closing stretch of the run.

module jpeg_exif_ifd_extractor_top_test;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_BYTES = 750;
    localparam logic [47:0] EXIF_ID      = 48'h457869660000;

    typedef enum int {
        FLAW_NONE,
        FLAW_NO_SOI,
        FLAW_SEG_TINY,
        FLAW_NO_MARK,
        FLAW_APP1_TINY,
        FLAW_APP1_SHORT,
        FLAW_SIG,
        FLAW_ORDER,
        FLAW_MAGIC,
        FLAW_OFS_LOW,
        FLAW_OFS_HIGH,
        FLAW_COUNT,
        FLAW_TRUNCATE
    } t_flaw;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata;   // [7:0] file_byte
    logic           s_axis_tlast;   // end_of_file
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    // [15:0] entry_number, [31:16] tag_id, [47:32] tag_type,
    // [79:48] value_count, [111:80] value_or_offset, [115:112] status, rest 0
    logic [119:0]   m_axis_tdata;
    logic           m_axis_tuser;   // result_kind
    logic           m_axis_tlast;   // last_of_run

    jpeg_exif_ifd_extractor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // parser model state
    jexif_pkg::t_phase ph;
    logic [15:0] skip_cnt;
    logic [15:0] app1_left;
    logic [15:0] tiff_cnt;
    logic        le_order;
    logic [31:0] acc;
    logic [3:0]  pos;
    logic [15:0] ents_left;
    logic [15:0] ent_idx;
    logic [31:0] tag_type_hold;
    logic [31:0] count_hold;
    logic        done;

    jexif_pkg::t_result ifd_results_due[$];
    logic [7:0]  file_q[$];
    int          seg_end;

    bit          src_idle;
    bit          sink_idle;
    int          errors;
    int          files_sent;
    int          bytes_sent;
    int          bytes_parsed;
    int          entries_checked;
    int          statuses_checked;
    logic [15:0] codes_seen;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout", $time);
        $display("jpeg_exif_ifd_extractor_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic logic [31:0] fold_byte(input logic [31:0] w, input logic [7:0] b,
                                              input logic [1:0] slot);
        if (le_order) begin
            return w | ({24'd0, b} << {slot, 3'b000});
        end
        return {w[23:0], b};
    endfunction

    task automatic restart_parser();
        ph            = jexif_pkg::PH_SOI0;
        skip_cnt      = '0;
        app1_left     = '0;
        tiff_cnt      = '0;
        le_order      = 1'b0;
        acc           = '0;
        pos           = '0;
        ents_left     = '0;
        ent_idx       = '0;
        tag_type_hold = '0;
        count_hold    = '0;
        done          = 1'b0;
    endtask

    task automatic close_parse(input logic [3:0] code);
        jexif_pkg::t_result r;
        r        = '0;
        r.kind   = jexif_pkg::KIND_STATUS;
        r.num    = ent_idx;
        r.status = code;
        r.last   = 1'b1;
        ifd_results_due.push_back(r);
        done = 1'b1;
    endtask

    task automatic predict_ifd_results(input logic [7:0] b, input logic eof);
        logic [3:0]  i;
        logic [3:0]  slot;
        logic [31:0] seg_len;
        int          sig_k;
        jexif_pkg::t_result r;
        i = pos;
        if (done) begin
            if (eof) restart_parser();
        end else begin
            if (ph >= jexif_pkg::PH_HDR) begin
                if (app1_left != 16'd0) app1_left = app1_left - 16'd1;
                if (tiff_cnt != 16'hFFFF && ph >= jexif_pkg::PH_ORDER) begin
                    tiff_cnt = tiff_cnt + 16'd1;
                end
            end
            case (ph)
                jexif_pkg::PH_SOI0: begin
                    if (b != jexif_pkg::MARK_BYTE) close_parse(jexif_pkg::ST_NOT_JPEG);
                    else ph = jexif_pkg::PH_SOI1;
                end
                jexif_pkg::PH_SOI1: begin
                    if (b != jexif_pkg::SOI_BYTE) close_parse(jexif_pkg::ST_NOT_JPEG);
                    else ph = jexif_pkg::PH_MARK0;
                end
                jexif_pkg::PH_MARK0: begin
                    if (b != jexif_pkg::MARK_BYTE) close_parse(jexif_pkg::ST_NO_EXIF);
                    else ph = jexif_pkg::PH_MARK1;
                end
                jexif_pkg::PH_MARK1: begin
                    ph = (b == jexif_pkg::APP1_BYTE) ? jexif_pkg::PH_ALEN0
                                                     : jexif_pkg::PH_SLEN0;
                end
                jexif_pkg::PH_SLEN0: begin
                    acc = {24'd0, b};
                    ph  = jexif_pkg::PH_SLEN1;
                end
                jexif_pkg::PH_ALEN0: begin
                    acc = {24'd0, b};
                    ph  = jexif_pkg::PH_ALEN1;
                end
                jexif_pkg::PH_SLEN1: begin
                    seg_len = {acc[23:0], b};
                    acc     = '0;
                    if (seg_len < 32'd2) begin
                        close_parse(jexif_pkg::ST_BAD_LENGTH);
                    end else begin
                        skip_cnt = seg_len[15:0] - 16'd2;
                        ph = (skip_cnt != 16'd0) ? jexif_pkg::PH_SKIP : jexif_pkg::PH_MARK0;
                    end
                end
                jexif_pkg::PH_SKIP: begin
                    if (skip_cnt != 16'd0) skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0) ph = jexif_pkg::PH_MARK0;
                end
                jexif_pkg::PH_ALEN1: begin
                    seg_len = {acc[23:0], b};
                    acc     = '0;
                    if (seg_len < 32'd2) begin
                        close_parse(jexif_pkg::ST_BAD_LENGTH);
                    end else if (seg_len - 32'd2 < 32'd14) begin
                        close_parse(jexif_pkg::ST_BAD_HEADER);
                    end else begin
                        app1_left = seg_len[15:0] - 16'd2;
                        tiff_cnt  = '0;
                        pos       = '0;
                        ph        = jexif_pkg::PH_HDR;
                    end
                end
                jexif_pkg::PH_HDR: begin
                    sig_k = (i < 4'd6) ? int'(i) : 5;
                    if (b != EXIF_ID[47 - 8 * sig_k -: 8]) begin
                        close_parse(jexif_pkg::ST_BAD_HEADER);
                    end else if (i >= 4'd5) begin
                        pos = '0;
                        ph  = jexif_pkg::PH_ORDER;
                    end else begin
                        pos = i + 4'd1;
                    end
                end
                jexif_pkg::PH_ORDER: begin
                    if (i == 4'd0) begin
                        acc = {24'd0, b};
                        pos = 4'd1;
                    end else if ((acc == {24'd0, jexif_pkg::ORDER_II} &&
                                  b == jexif_pkg::ORDER_II) ||
                                 (acc == {24'd0, jexif_pkg::ORDER_MM} &&
                                  b == jexif_pkg::ORDER_MM)) begin
                        le_order = (b == jexif_pkg::ORDER_II);
                        acc      = '0;
                        pos      = '0;
                        ph       = jexif_pkg::PH_MAGIC;
                    end else begin
                        close_parse(jexif_pkg::ST_BAD_ORDER);
                    end
                end
                jexif_pkg::PH_MAGIC: begin
                    acc = fold_byte(acc, b, i[1:0]);
                    if (i == 4'd0) begin
                        pos = 4'd1;
                    end else if (acc != jexif_pkg::TIFF_MAGIC) begin
                        close_parse(jexif_pkg::ST_BAD_MAGIC);
                    end else begin
                        acc = '0;
                        pos = '0;
                        ph  = jexif_pkg::PH_OFFSET;
                    end
                end
                jexif_pkg::PH_OFFSET: begin
                    acc = fold_byte(acc, b, i[1:0]);
                    if (i < 4'd3) begin
                        pos = i + 4'd1;
                    end else begin
                        pos = '0;
                        // the 2-byte count must still fit in the segment
                        if (acc < 32'd8 ||
                            ({32'd0, acc} + 64'd2) > ({48'd0, app1_left} + 64'd8)) begin
                            close_parse(jexif_pkg::ST_BAD_OFFSET);
                        end else begin
                            skip_cnt = acc[15:0] - tiff_cnt;
                            acc      = '0;
                            ph       = (skip_cnt != 16'd0) ? jexif_pkg::PH_GAP
                                                           : jexif_pkg::PH_COUNT;
                        end
                    end
                end
                jexif_pkg::PH_GAP: begin
                    if (skip_cnt != 16'd0) skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0) ph = jexif_pkg::PH_COUNT;
                end
                jexif_pkg::PH_COUNT: begin
                    acc = fold_byte(acc, b, i[1:0]);
                    if (i == 4'd0) begin
                        pos = 4'd1;
                    end else begin
                        pos       = '0;
                        ents_left = acc[15:0];
                        acc       = '0;
                        ent_idx   = '0;
                        if (({16'd0, ents_left} * 32'd12) > {16'd0, app1_left}) begin
                            close_parse(jexif_pkg::ST_BAD_OFFSET);
                        end else if (ents_left == 16'd0) begin
                            close_parse(jexif_pkg::ST_OK);
                        end else begin
                            ph = jexif_pkg::PH_ENTRY;
                        end
                    end
                end
                jexif_pkg::PH_ENTRY: begin
                    if (i > jexif_pkg::ENTRY_LAST) i = '0;
                    if (i < 4'd2)      slot = i;
                    else if (i < 4'd4) slot = i - 4'd2;
                    else if (i < 4'd8) slot = i - 4'd4;
                    else               slot = i - 4'd8;
                    acc = fold_byte(acc, b, slot[1:0]);
                    if (i == 4'd1) begin
                        tag_type_hold = acc << 16;
                        acc = '0;
                    end else if (i == 4'd3) begin
                        tag_type_hold = tag_type_hold | {16'd0, acc[15:0]};
                        acc = '0;
                    end else if (i == 4'd7) begin
                        count_hold = acc;
                        acc = '0;
                    end
                    if (i < jexif_pkg::ENTRY_LAST) begin
                        pos = i + 4'd1;
                    end else begin
                        r       = '0;
                        r.kind  = jexif_pkg::KIND_ENTRY;
                        r.num   = ent_idx;
                        r.tag   = tag_type_hold[31:16];
                        r.ttype = tag_type_hold[15:0];
                        r.cnt   = count_hold;
                        r.val   = acc;
                        ifd_results_due.push_back(r);
                        acc     = '0;
                        pos     = '0;
                        ent_idx = ent_idx + 16'd1;
                        if (ents_left != 16'd0) ents_left = ents_left - 16'd1;
                        if (ents_left == 16'd0) close_parse(jexif_pkg::ST_OK);
                    end
                end
                default: ;
            endcase
            if (eof) begin
                if (!done) close_parse(jexif_pkg::ST_EARLY_END);
                restart_parser();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // file assembly
    // ------------------------------------------------------------------
    task automatic put_half(input logic [15:0] v, input logic le);
        if (le) begin
            file_q.push_back(v[7:0]);
            file_q.push_back(v[15:8]);
        end else begin
            file_q.push_back(v[15:8]);
            file_q.push_back(v[7:0]);
        end
    endtask

    task automatic put_word(input logic [31:0] v, input logic le);
        if (le) begin
            put_half(v[15:0], le);
            put_half(v[31:16], le);
        end else begin
            put_half(v[31:16], le);
            put_half(v[15:0], le);
        end
    endtask

    // SOI, optional segments to skip, then APP1 with header, gap, IFD0 and pad, then up to three trailing bytes
    task automatic compose_file(input logic le, input int n_ent, input int gap,
                                input int pre_segs, input int pad, input bit fill_ent,
                                input t_flaw flaw);
        int          data_len;
        int          k;
        int          seg_bytes;
        int          bad_k;
        int          cut;
        logic [7:0]  mk;
        logic [7:0]  ord;
        logic [7:0]  b;
        logic [31:0] ofs;
        logic [15:0] cnt_field;
        file_q.delete();
        if (flaw == FLAW_SEG_TINY && pre_segs == 0) pre_segs = 1;
        if (flaw == FLAW_NO_SOI) begin
            if ($urandom_range(0, 1) != 0) begin
                file_q.push_back(8'($urandom_range(0, 254)));
            end else begin
                file_q.push_back(jexif_pkg::MARK_BYTE);
                b = 8'($urandom_range(0, 255));
                if (b == jexif_pkg::SOI_BYTE) b = 8'h00;
                file_q.push_back(b);
            end
        end else begin
            file_q.push_back(jexif_pkg::MARK_BYTE);
            file_q.push_back(jexif_pkg::SOI_BYTE);
        end
        for (k = 0; k < pre_segs; k++) begin
            mk = 8'($urandom_range(0, 255));
            if (mk == jexif_pkg::APP1_BYTE) mk = jexif_pkg::MARK_BYTE;
            file_q.push_back(jexif_pkg::MARK_BYTE);
            file_q.push_back(mk);
            if (flaw == FLAW_SEG_TINY && k == 0) begin
                put_half(16'($urandom_range(0, 1)), 1'b0);
            end else begin
                seg_bytes = int'($urandom_range(0, 6));
                put_half(16'(seg_bytes + 2), 1'b0);
                repeat (seg_bytes) file_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (flaw == FLAW_NO_MARK) file_q.push_back(8'($urandom_range(0, 254)));
        file_q.push_back(jexif_pkg::MARK_BYTE);
        file_q.push_back(jexif_pkg::APP1_BYTE);
        data_len = 14 + gap + 2 + 12 * n_ent + pad;
        if (flaw == FLAW_APP1_TINY)       put_half(16'($urandom_range(0, 1)), 1'b0);
        else if (flaw == FLAW_APP1_SHORT) put_half(16'($urandom_range(2, 15)), 1'b0);
        else                              put_half(16'(data_len + 2), 1'b0);
        bad_k = int'($urandom_range(0, 5));
        for (k = 0; k < 6; k++) begin
            b = EXIF_ID[47 - 8 * k -: 8];
            if (flaw == FLAW_SIG && k == bad_k) b = b ^ 8'($urandom_range(1, 255));
            file_q.push_back(b);
        end
        ord = le ? jexif_pkg::ORDER_II : jexif_pkg::ORDER_MM;
        if (flaw == FLAW_ORDER) begin
            if ($urandom_range(0, 3) == 0) begin
                file_q.push_back(8'($urandom_range(0, 255)));
                file_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                file_q.push_back(ord);
                file_q.push_back(ord ^ 8'($urandom_range(1, 255)));
            end
        end else begin
            file_q.push_back(ord);
            file_q.push_back(ord);
        end
        if (flaw == FLAW_MAGIC) put_half(16'd42 ^ 16'($urandom_range(1, 65535)), le);
        else                    put_half(16'd42, le);
        if (flaw == FLAW_OFS_LOW) begin
            ofs = 32'($urandom_range(0, 7));
        end else if (flaw == FLAW_OFS_HIGH) begin
            // one to four past the last offset whose count still fits, or far out
            if ($urandom_range(0, 1) != 0) ofs = 32'(data_len - 7) + 32'($urandom_range(0, 3));
            else                           ofs = $urandom | 32'h8000_0000;
        end else begin
            ofs = 32'(8 + gap);
        end
        put_word(ofs, le);
        repeat (gap) file_q.push_back(8'($urandom_range(0, 255)));
        if (flaw == FLAW_COUNT) begin
            cnt_field = 16'(n_ent + pad / 12 + 1) + 16'($urandom_range(0, 2));
        end else begin
            cnt_field = 16'(n_ent);
        end
        put_half(cnt_field, le);
        for (k = 0; k < n_ent; k++) begin
            if (fill_ent) begin
                put_half((k % 2 == 0) ? 16'hFFFF : 16'h0000, le);
                put_half((k % 2 == 0) ? 16'hFFFF : 16'h0000, le);
                put_word((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0, le);
                put_word((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0, le);
            end else begin
                put_half(16'($urandom), le);
                put_half(16'($urandom), le);
                put_word($urandom, le);
                put_word($urandom, le);
            end
        end
        repeat (pad) file_q.push_back(8'($urandom_range(0, 255)));
        seg_end = file_q.size();
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(0, 255)));
        if (flaw == FLAW_TRUNCATE) begin
            cut = int'($urandom_range(1, file_q.size() - 1));
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (src_idle && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (!done) bytes_parsed++;
        predict_ifd_results(b, eof);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        int k;
        files_sent++;
        for (k = 0; k < file_q.size(); k++) begin
            send_byte(file_q[k], k == file_q.size() - 1);
        end
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input int n);
        file_q.delete();
        file_q.push_back(b0);
        if (n > 1) file_q.push_back(b1);
        send_file();
    endtask

    task automatic test_start_marker();
        send_bytes(8'h00, 8'h00, 1);
        send_bytes(jexif_pkg::MARK_BYTE, 8'h00, 1);
        send_bytes(jexif_pkg::MARK_BYTE, jexif_pkg::SOI_BYTE, 2);
        compose_file(1'b0, 0, 0, 0, 0, 1'b0, FLAW_NO_SOI);
        send_file();
        compose_file(1'b1, 0, 0, 0, 0, 1'b0, FLAW_NO_SOI);
        send_file();
    endtask

    task automatic test_segment_walk();
        compose_file(1'b0, 0, 0, 2, 0, 1'b0, FLAW_NONE);
        file_q[3] = jexif_pkg::MARK_BYTE;  // FF FF opens a segment, not fill
        send_file();
        compose_file(1'b1, 0, 0, 1, 0, 1'b0, FLAW_SEG_TINY);
        send_file();
        compose_file(1'b0, 0, 0, 1, 0, 1'b0, FLAW_NO_MARK);
        send_file();
        compose_file(1'b1, 0, 0, 0, 0, 1'b0, FLAW_APP1_TINY);
        send_file();
    endtask

    task automatic test_exif_header();
        compose_file(1'b0, 0, 0, 0, 0, 1'b0, FLAW_APP1_SHORT);
        send_file();
        compose_file(1'b1, 0, 0, 0, 0, 1'b0, FLAW_SIG);
        send_file();
        compose_file(1'b1, 0, 0, 0, 0, 1'b0, FLAW_ORDER);
        send_file();
        compose_file(1'b0, 0, 0, 0, 0, 1'b0, FLAW_MAGIC);
        send_file();
        compose_file(1'b1, 0, 0, 0, 0, 1'b0, FLAW_MAGIC);
        send_file();
    endtask

    task automatic test_ifd_offset();
        compose_file(1'b1, 1, 0, 0, 0, 1'b0, FLAW_OFS_LOW);
        send_file();
        compose_file(1'b0, 1, 2, 0, 0, 1'b0, FLAW_OFS_HIGH);
        send_file();
        compose_file(1'b1, 1, 0, 0, 4, 1'b0, FLAW_COUNT);
        send_file();
        // empty directory with the count in the last two segment bytes
        compose_file(1'b0, 0, 3, 0, 0, 1'b0, FLAW_NONE);
        send_file();
    endtask

    task automatic test_directory();
        compose_file(1'b1, 2, 0, 0, 0, 1'b1, FLAW_NONE);
        send_file();
        compose_file(1'b0, 2, 1, 0, 5, 1'b1, FLAW_NONE);
        send_file();
        // end of file on the byte that completes the last entry
        compose_file(1'b0, 1, 0, 0, 0, 1'b0, FLAW_NONE);
        while (file_q.size() > seg_end) void'(file_q.pop_back());
        send_file();
        // end of file one byte short of the last entry
        compose_file(1'b1, 1, 0, 0, 0, 1'b0, FLAW_NONE);
        while (file_q.size() > seg_end - 1) void'(file_q.pop_back());
        send_file();
    endtask

    task automatic test_random_files();
        int    start_bytes;
        int    pick;
        int    n_ent;
        int    gap;
        t_flaw flaw;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (bytes_sent - start_bytes > RANDOM_BYTES - 200) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 8) begin
                file_q.delete();
                if (pick < 4) begin
                    file_q.push_back(jexif_pkg::MARK_BYTE);
                    file_q.push_back(jexif_pkg::SOI_BYTE);
                end
                repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                if (pick < 60)      flaw = FLAW_NONE;
                else if (pick < 70) flaw = FLAW_TRUNCATE;
                else                flaw = t_flaw'($urandom_range(FLAW_NO_SOI, FLAW_COUNT));
                n_ent = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 14))
                                                    : int'($urandom_range(0, 4));
                gap   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 200))
                                                    : int'($urandom_range(0, 4));
                compose_file(1'($urandom_range(0, 1)), n_ent, gap,
                             int'($urandom_range(0, 2)), int'($urandom_range(0, 13)),
                             $urandom_range(0, 9) == 0, flaw);
            end
            send_file();
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin : sink_side
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_idle && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        jexif_pkg::t_result due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ifd_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b tlast %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                due = ifd_results_due.pop_front();
                check_field("result_kind", 32'(due.kind), 32'(m_axis_tuser));
                check_field("entry_number", 32'(due.num), 32'(m_axis_tdata[15:0]));
                check_field("tag_id", 32'(due.tag), 32'(m_axis_tdata[31:16]));
                check_field("tag_type", 32'(due.ttype), 32'(m_axis_tdata[47:32]));
                check_field("value_count", due.cnt, m_axis_tdata[79:48]);
                check_field("value_or_offset", due.val, m_axis_tdata[111:80]);
                check_field("status", 32'(due.status), 32'(m_axis_tdata[115:112]));
                check_field("tdata fill", 32'd0, 32'(m_axis_tdata[119:116]));
                check_field("last_of_run", 32'(due.last), 32'(m_axis_tlast));
                if (due.kind == jexif_pkg::KIND_STATUS) begin
                    statuses_checked++;
                    codes_seen[due.status] = 1'b1;
                end else begin
                    entries_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        src_idle         = 1'b1;
        sink_idle        = 1'b1;
        errors           = 0;
        files_sent       = 0;
        bytes_sent       = 0;
        bytes_parsed     = 0;
        entries_checked  = 0;
        statuses_checked = 0;
        codes_seen       = '0;
        restart_parser();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_marker();
        test_segment_walk();
        test_exif_header();
        test_ifd_offset();
        test_directory();
        test_random_files();

        s_axis_tvalid <= 1'b0;
        while (ifd_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d files, %0d bytes (%0d parsed); checked %0d entries and %0d statuses",
                 files_sent, bytes_sent, bytes_parsed, entries_checked, statuses_checked);
        $display("Status codes returned (bit per code): 0x%0h", codes_seen);
        if (errors == 0) begin
            $display("jpeg_exif_ifd_extractor_top test passed");
        end else begin
            $display("jpeg_exif_ifd_extractor_top test failed");
        end
        $finish;
    end

endmodule
